@@ rtl/fmtint_pkg.sv @@
// Shared types and character codes for the integer-to-text formatter.
`default_nettype none
package fmtint_pkg;

    localparam int unsigned NUM_DIGITS = 22;
    localparam int unsigned DEC_DIGITS = 20;
    localparam int unsigned HEX_DIGITS = 16;
    localparam int unsigned ARG_BITS   = 64;
    localparam int unsigned DIG_IDX_W  = 5;
    localparam logic [5:0]  CONV_LAST  = 6'd63;
    localparam logic [DIG_IDX_W-1:0] FRAC_TOP   = 5'd7;
    localparam logic [DIG_IDX_W-1:0] WHOLE_LOW  = 5'd8;
    localparam logic [DIG_IDX_W-1:0] PTR_TOP    = 5'd15;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_T    = 8'h54;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_C    = 8'h63;
    localparam logic [7:0] CH_LO_D    = 8'h64;
    localparam logic [7:0] CH_LO_I    = 8'h69;
    localparam logic [7:0] CH_LO_L    = 8'h6C;
    localparam logic [7:0] CH_LO_O    = 8'h6F;
    localparam logic [7:0] CH_LO_P    = 8'h70;
    localparam logic [7:0] CH_LO_Q    = 8'h71;
    localparam logic [7:0] CH_LO_U    = 8'h75;
    localparam logic [7:0] CH_LO_V    = 8'h76;
    localparam logic [7:0] CH_LO_X    = 8'h78;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;

    typedef enum logic [1:0] {
        MODE_LIT,
        MODE_PCT,
        MODE_L,
        MODE_LL
    } fmt_mode_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ECHO,
        OP_PCT,
        OP_ARGB,
        OP_DEC,
        OP_AMT,
        OP_OCT,
        OP_HEXL,
        OP_HEXU,
        OP_PTR
    } fmt_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_PREP,
        S_BUILD,
        S_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        G_CHR,
        G_PRE0,
        G_PRE1,
        G_DIG,
        G_DOT,
        G_FRAC,
        G_DONE
    } gen_phase_t;

    typedef struct packed {
        logic    load;
        fmt_op_t op;
        logic    sgn;
        logic    wide;
        logic    dabble;
        logic    prep;
        logic    build;
        logic    emit_adv;
    } dp_cmd_t;

    typedef struct packed {
        logic build_done;
        logic emit_last;
    } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/fmtint_ctrl.sv @@
// Controller: format mode tracking, decode, and sequencing of one item.
`default_nettype none
module fmtint_ctrl
    import fmtint_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] fmt_char,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output dp_cmd_t         cmd,
    input  wire dp_status_t status
);

    ctrl_state_t state_reg, state_next;
    fmt_mode_t   mode_reg, mode_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        wide_cfg_reg;

    function automatic fmt_op_t int_op(input logic [7:0] ch);
        fmt_op_t op;
        begin
            case (ch)
                CH_LO_D, CH_LO_I: op = OP_DEC;
                CH_LO_U:          op = OP_DEC;
                CH_LO_O:          op = OP_OCT;
                CH_LO_X:          op = OP_HEXL;
                CH_UP_X:          op = OP_HEXU;
                default:          op = OP_NONE;
            endcase
            return op;
        end
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= MODE_LIT;
            cnt_reg      <= '0;
            wide_cfg_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid)
                wide_cfg_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    mode_next = MODE_LIT;
                    case (mode_reg)
                        MODE_LIT:
                        begin
                            if (fmt_char == CH_PERCENT)
                                mode_next = MODE_PCT;
                            else
                                cmd.op = OP_ECHO;
                        end
                        MODE_PCT:
                        begin
                            case (fmt_char)
                                CH_PERCENT: cmd.op = OP_PCT;
                                CH_LO_C:    cmd.op = OP_ARGB;
                                CH_LO_P:
                                begin
                                    cmd.op   = OP_PTR;
                                    cmd.wide = 1'b1;
                                end
                                CH_UP_T:
                                begin
                                    cmd.op   = OP_DEC;
                                    cmd.sgn  = 1'b1;
                                    cmd.wide = 1'b1;
                                end
                                CH_LO_V:
                                begin
                                    cmd.op   = OP_AMT;
                                    cmd.sgn  = 1'b1;
                                    cmd.wide = 1'b1;
                                end
                                CH_LO_L:          mode_next = MODE_L;
                                CH_LO_Q, CH_LO_Z: mode_next = MODE_LL;
                                default:
                                begin
                                    cmd.op  = int_op(fmt_char);
                                    cmd.sgn = (fmt_char == CH_LO_D) || (fmt_char == CH_LO_I);
                                end
                            endcase
                        end
                        MODE_L:
                        begin
                            if (fmt_char == CH_LO_L)
                                mode_next = MODE_LL;
                            else
                            begin
                                cmd.op   = int_op(fmt_char);
                                cmd.sgn  = (fmt_char == CH_LO_D) || (fmt_char == CH_LO_I);
                                cmd.wide = wide_cfg_reg;
                            end
                        end
                        default:
                        begin
                            cmd.op   = int_op(fmt_char);
                            cmd.sgn  = (fmt_char == CH_LO_D) || (fmt_char == CH_LO_I);
                            cmd.wide = 1'b1;
                        end
                    endcase
                    if (cmd.op != OP_NONE)
                    begin
                        cmd.load = 1'b1;
                        cnt_next = '0;
                        if ((cmd.op == OP_DEC) || (cmd.op == OP_AMT))
                            state_next = S_CONV;
                        else
                            state_next = S_PREP;
                    end
                end
            end
            S_CONV:
            begin
                cmd.dabble = 1'b1;
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == CONV_LAST)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_BUILD;
            end
            S_BUILD:
            begin
                cmd.build = 1'b1;
                if (status.build_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                m_tvalid     = 1'b1;
                cmd.emit_adv = m_tready;
                if (m_tready && status.emit_last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/fmtint_dp.sv @@
// Datapath: sign handling, binary-to-BCD shifter, text builder and character store.
`default_nettype none
module fmtint_dp
    import fmtint_pkg::*;
#(
    parameter int unsigned MAX_CHARS = 22
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  fmt_char,
    input  wire logic [63:0] arg_value,
    input  wire dp_cmd_t     cmd,
    output dp_status_t       status,
    output logic [7:0]       out_char
);

    localparam int unsigned IW = $clog2(MAX_CHARS);
    localparam int unsigned CW = $clog2(MAX_CHARS + 1);

    fmt_op_t        op_reg;
    logic           neg_reg;
    logic [7:0]     char_reg;
    logic [63:0]    val_reg;
    logic [79:0]    bcd_reg;
    logic           frac_nz_reg;
    gen_phase_t     gph_reg, gph_next;
    logic [DIG_IDX_W-1:0] idx_reg, idx_next;
    logic [CW-1:0]  wr_reg, rd_reg;
    logic [7:0]     out_char_reg;
    logic [7:0]     digit_store [MAX_CHARS];

    logic [63:0]    v_sel, v_mag;
    logic [79:0]    bcd_adj;
    logic [65:0]    val_ext;
    logic [3:0]     dig [NUM_DIGITS];
    logic [DIG_IDX_W-1:0] hnz, top, stop;
    logic [3:0]     dsel;
    logic [7:0]     dchar, wch;
    logic           we;
    logic [CW-1:0]  rd_sel;

    // Sign-extend or zero-extend the argument, then take its magnitude.
    always_comb
    begin
        v_sel = cmd.wide ? arg_value : {32'd0, arg_value[31:0]};
        if (cmd.sgn && !cmd.wide && arg_value[31])
            v_sel[63:32] = '1;
        v_mag = (cmd.sgn && v_sel[63]) ? (~v_sel + 64'd1) : v_sel;
    end

    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // Digit vector, least significant first, in the radix of the operation.
    assign val_ext = {2'b00, val_reg};
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            case (op_reg)
                OP_DEC, OP_AMT:
                    dig[i] = (i < DEC_DIGITS) ? bcd_reg[4*(i % DEC_DIGITS) +: 4] : 4'd0;
                OP_HEXL, OP_HEXU, OP_PTR:
                    dig[i] = (i < HEX_DIGITS) ? val_reg[4*(i % HEX_DIGITS) +: 4] : 4'd0;
                OP_OCT:
                    dig[i] = {1'b0, val_ext[3*i +: 3]};
                default:
                    dig[i] = 4'd0;
            endcase
        end
    end

    always_comb
    begin
        hnz = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (dig[i] != 4'd0)
                hnz = DIG_IDX_W'(i);
        end
        if (op_reg == OP_PTR)
            top = PTR_TOP;
        else if ((op_reg == OP_AMT) && (hnz < WHOLE_LOW))
            top = WHOLE_LOW;
        else
            top = hnz;
        stop = (op_reg == OP_AMT) ? WHOLE_LOW : '0;
    end

    always_comb
    begin
        dsel = dig[idx_reg];
        if (dsel < 4'd10)
            dchar = CH_ZERO + {4'd0, dsel};
        else if (op_reg == OP_HEXU)
            dchar = CH_UP_A + {4'd0, dsel} - 8'd10;
        else
            dchar = CH_LO_A + {4'd0, dsel} - 8'd10;
    end

    // Text builder: one step per cycle, at most one character written.
    always_comb
    begin
        gph_next = gph_reg;
        idx_next = idx_reg;
        we       = 1'b0;
        wch      = dchar;
        if (cmd.build)
        begin
            case (gph_reg)
                G_CHR:
                begin
                    we       = 1'b1;
                    wch      = char_reg;
                    gph_next = G_DONE;
                end
                G_PRE0:
                begin
                    we       = neg_reg || (op_reg == OP_PTR);
                    wch      = (op_reg == OP_PTR) ? CH_ZERO : CH_MINUS;
                    gph_next = G_PRE1;
                end
                G_PRE1:
                begin
                    we       = (op_reg == OP_PTR);
                    wch      = CH_LO_X;
                    gph_next = G_DIG;
                end
                G_DIG:
                begin
                    we = 1'b1;
                    if (idx_reg == stop)
                        gph_next = ((op_reg == OP_AMT) && frac_nz_reg) ? G_DOT : G_DONE;
                    else
                        idx_next = idx_reg - 5'd1;
                end
                G_DOT:
                begin
                    we       = 1'b1;
                    wch      = CH_POINT;
                    idx_next = FRAC_TOP;
                    gph_next = G_FRAC;
                end
                G_FRAC:
                begin
                    we = 1'b1;
                    if (idx_reg == '0)
                        gph_next = G_DONE;
                    else
                        idx_next = idx_reg - 5'd1;
                end
                default: gph_next = G_DONE;
            endcase
        end
        else if (cmd.prep)
        begin
            idx_next = top;
            if ((op_reg == OP_ECHO) || (op_reg == OP_PCT) || (op_reg == OP_ARGB))
                gph_next = G_CHR;
            else
                gph_next = G_PRE0;
        end
    end

    // Prefetch the next character so the output always comes from a register.
    assign rd_sel = cmd.emit_adv ? (rd_reg + CW'(1)) : rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gph_reg <= G_DONE;
            idx_reg <= '0;
            wr_reg  <= '0;
            rd_reg  <= '0;
        end
        else
        begin
            gph_reg <= gph_next;
            idx_reg <= idx_next;
            if (cmd.prep)
            begin
                wr_reg <= '0;
                rd_reg <= '0;
            end
            else
            begin
                if (we)
                    wr_reg <= wr_reg + CW'(1);
                if (cmd.emit_adv)
                    rd_reg <= rd_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= cmd.op;
            neg_reg <= cmd.sgn && v_sel[63];
            val_reg <= v_mag;
            bcd_reg <= '0;
            case (cmd.op)
                OP_PCT:  char_reg <= CH_PERCENT;
                OP_ARGB: char_reg <= arg_value[7:0];
                default: char_reg <= fmt_char;
            endcase
        end
        else if (cmd.dabble)
        begin
            bcd_reg <= {bcd_adj[78:0], val_reg[63]};
            val_reg <= {val_reg[62:0], 1'b0};
        end
        if (cmd.prep)
            frac_nz_reg <= (bcd_reg[31:0] != 32'd0);
        if (we)
            digit_store[wr_reg[IW-1:0]] <= wch;
        if (rd_sel < CW'(MAX_CHARS))
            out_char_reg <= digit_store[rd_sel[IW-1:0]];
    end

    assign out_char          = out_char_reg;
    assign status.emit_last  = ((rd_reg + CW'(1)) == wr_reg);
    assign status.build_done = (gph_reg == G_DONE);

endmodule
`default_nettype wire

@@ rtl/format_integer_to_text.sv @@
// Top level of the integer-to-text formatter.
//
//  channel   dir  handshake                    payload
//  s_*       in   s_tvalid / s_tready          s_tdata[7:0] fmt_char, [71:8] arg_value
//  m_*       out  m_tvalid / m_tready          m_tdata[7:0] out_char, m_tlast last
//  cfg_*     in   cfg_valid / cfg_ready        cfg_data long_is_wide
//
// One item at a time. Setup, then the BCD shifter for decimal conversions, then prep
// and the builder, then the characters (up to 22) go out one by one as the sink takes them.
// Items that make no text are taken in the idle state.
// Reset returns to literal mode with long_is_wide = 1; cfg_ready is always high.
`default_nettype none
module format_integer_to_text
    import fmtint_pkg::*;
#(
    parameter int unsigned MAX_CHARS = 22
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // fmt_char, arg_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_char
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    fmtint_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .fmt_char  (s_tdata[7:0]),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    fmtint_dp #(
        .MAX_CHARS (MAX_CHARS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .fmt_char  (s_tdata[7:0]),
        .arg_value (s_tdata[71:8]),
        .cmd       (cmd),
        .status    (status),
        .out_char  (m_tdata)
    );

    assign m_tlast = status.emit_last;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while text pending");

    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not ready after final character");

    a_build_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> status.build_done)
        else $error("emitting before text complete");
`endif

endmodule
`default_nettype wire

@@ tb/format_integer_to_text_tb.sv @@
// Self-checking testbench for the integer-to-text formatter.
`timescale 1ns / 1ps

module format_integer_to_text_tb;
    import fmtint_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    class text_scoreboard;
        fmt_mode_t    mode;
        bit           long_wide;
        text_char_t   pending[$];
        byte unsigned line[$];
        int           errors;

        function new();
            mode = MODE_LIT;
            long_wide = 1'b1;
            errors = 0;
        endfunction

        function void put_dec(logic [63:0] v, int min_digits);
            byte unsigned tmp[$];
            do
            begin
                tmp.push_front(8'(CH_ZERO + 64'(v % 10)));
                v = v / 10;
            end while (v != 0);
            while (tmp.size() < min_digits)
                tmp.push_front(CH_ZERO);
            foreach (tmp[k])
                line.push_back(tmp[k]);
        endfunction

        function void put_pow2(logic [63:0] v, int bits, logic [7:0] alpha, int min_digits);
            byte unsigned tmp[$];
            logic [63:0] msk;
            logic [7:0] d;
            msk = (64'd1 << bits) - 1;
            do
            begin
                d = 8'(v & msk);
                tmp.push_front(d < 10 ? CH_ZERO + d : alpha - 8'd10 + d);
                v = v >> bits;
            end while (v != 0);
            while (tmp.size() < min_digits)
                tmp.push_front(CH_ZERO);
            foreach (tmp[k])
                line.push_back(tmp[k]);
        endfunction

        function logic [63:0] strip_sign(logic [63:0] v);
            if (v[63])
            begin
                line.push_back(CH_MINUS);
                return ~v + 1;
            end
            return v;
        endfunction

        function void put_int(logic [7:0] ch, logic [63:0] arg, bit wide);
            logic [63:0] v;
            v = wide ? arg : {32'd0, arg[31:0]};
            case (ch)
                CH_LO_D, CH_LO_I:
                begin
                    if (!wide && v[31])
                        v[63:32] = '1;
                    put_dec(strip_sign(v), 1);
                end
                CH_LO_O: put_pow2(v, 3, CH_LO_A, 1);
                CH_LO_U: put_dec(v, 1);
                CH_LO_X: put_pow2(v, 4, CH_LO_A, 1);
                CH_UP_X: put_pow2(v, 4, CH_UP_A, 1);
                default: ;
            endcase
        endfunction

        // Predict the text for one accepted item and queue it.
        function void note_item(logic [7:0] ch, logic [63:0] arg);
            logic [63:0] mag;
            text_char_t t;
            line.delete();
            case (mode)
                MODE_LIT:
                    if (ch == CH_PERCENT)
                        mode = MODE_PCT;
                    else
                        line.push_back(ch);
                MODE_PCT:
                begin
                    mode = MODE_LIT;
                    case (ch)
                        CH_PERCENT: line.push_back(CH_PERCENT);
                        CH_LO_C: line.push_back(arg[7:0]);
                        CH_LO_P:
                        begin
                            line.push_back(CH_ZERO);
                            line.push_back(CH_LO_X);
                            put_pow2(arg, 4, CH_LO_A, 16);
                        end
                        CH_UP_T: put_dec(strip_sign(arg), 1);
                        CH_LO_V:
                        begin
                            mag = strip_sign(arg);
                            put_dec(mag / 64'd100000000, 1);
                            if (mag % 64'd100000000 != 0)
                            begin
                                line.push_back(CH_POINT);
                                put_dec(mag % 64'd100000000, 8);
                            end
                        end
                        CH_LO_L: mode = MODE_L;
                        CH_LO_Q, CH_LO_Z: mode = MODE_LL;
                        default: put_int(ch, arg, 1'b0);
                    endcase
                end
                MODE_L:
                begin
                    mode = MODE_LIT;
                    if (ch == CH_LO_L)
                        mode = MODE_LL;
                    else
                        put_int(ch, arg, long_wide);
                end
                default:
                begin
                    mode = MODE_LIT;
                    put_int(ch, arg, 1'b1);
                end
            endcase
            foreach (line[k])
            begin
                t.ch = line[k];
                t.last = (k == line.size() - 1);
                pending.push_back(t);
            end
        endfunction

        task check_char(logic [7:0] ch, logic last);
            text_char_t t;
            if (pending.size() == 0)
            begin
                report("unexpected character", ch, 0);
                return;
            end
            t = pending.pop_front();
            if (ch !== t.ch)
                report("char mismatch", ch, t.ch);
            if (last !== t.last)
                report("last mismatch", last, t.last);
        endtask

        task report(string what, logic [63:0] got, logic [63:0] exp_v);
            $display("ERROR %s: got %h, expected %h", what, got, exp_v);
            errors++;
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;  // fmt_char [7:0], arg_value [71:8]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;       // out_char
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    text_scoreboard sb;
    int idle_cycles = 0;
    bit sink_on = 1'b0;
    localparam int WATCHDOG = 20000;

    format_integer_to_text i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sample results and count quiet cycles for the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_char(m_tdata, m_tlast);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG)
            begin
                $display("format_integer_to_text_tb failed");
                $finish;
            end
        end
    end

    // Sink with random stalls, including stretches of none.
    initial
    begin
        int g;
        int calm;
        calm = 0;
        forever
        begin
            @(negedge clk);
            if (!sink_on)
                m_tready <= 1'b0;
            else if (calm > 0)
            begin
                m_tready <= 1'b1;
                calm--;
            end
            else
            begin
                if ($urandom_range(0, 30) == 0)
                    calm = $urandom_range(20, 80);
                g = gap_len();
                m_tready <= (g == 0);
                repeat (g > 0 ? g - 1 : 0) @(negedge clk);
            end
        end
    end

    // Valid stays high after an accept; the next call or drain decides what follows.
    task automatic send_item(logic [7:0] ch, logic [63:0] arg, bit no_gap = 0);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {arg, ch};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(ch, arg);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_wide(bit v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.long_wide = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand_arg();
        logic [63:0] a;
        a = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: a = a >> $urandom_range(0, 63);
            1: a = 64'h8000_0000_0000_0000;
            2: a = '1;
            3: a = 0;
            4: a = {32'd0, 32'h8000_0000};
            5: a = 64'($urandom_range(0, 999)) * 64'd100000000;
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] rand_conv();
        logic [7:0] list[6];
        list = '{CH_LO_D, CH_LO_I, CH_LO_O, CH_LO_U, CH_LO_X, CH_UP_X};
        return list[$urandom_range(0, 5)];
    endfunction

    // One format sequence: mostly well formed, some noise.
    task automatic send_sequence();
        logic [7:0] top[7];
        int r;
        top = '{CH_PERCENT, CH_LO_C, CH_LO_P, CH_UP_T, CH_LO_V, 8'h73, 8'h6E};
        r = $urandom_range(0, 99);
        if (r < 15)
            send_item(8'($urandom), rand_arg());
        else
        begin
            send_item(CH_PERCENT, rand_arg());
            if (r < 35)
                send_item(top[$urandom_range(0, 6)], rand_arg());
            else if (r < 55)
                send_item(rand_conv(), rand_arg());
            else if (r < 70)
            begin
                send_item(CH_LO_L, rand_arg());
                send_item(rand_conv(), rand_arg());
            end
            else if (r < 85)
            begin
                case ($urandom_range(0, 2))
                    0: begin send_item(CH_LO_L, rand_arg()); send_item(CH_LO_L, rand_arg()); end
                    1: send_item(CH_LO_Q, rand_arg());
                    default: send_item(CH_LO_Z, rand_arg());
                endcase
                send_item($urandom_range(0, 9) == 0 ? 8'($urandom) : rand_conv(), rand_arg());
            end
            else
                send_item(8'($urandom), rand_arg());
        end
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        sink_on = 1'b1;

        // Directed: echo, percent, char, pointer, signed and amount forms, plus decimal, octal and unknown conversions.
        send_item(8'h41, 0);
        send_item(8'h00, '1);
        send_item(8'hFF, 0);
        send_item(CH_PERCENT, 0); send_item(CH_PERCENT, 0);
        send_item(CH_PERCENT, 0); send_item(CH_LO_C, 64'h1234_5678_9ABC_DEFF);
        send_item(CH_PERCENT, 0); send_item(CH_LO_P, '1);
        send_item(CH_PERCENT, 0); send_item(CH_UP_T, 64'h8000_0000_0000_0000);
        send_item(CH_PERCENT, 0); send_item(CH_LO_V, 64'd100000005);
        send_item(CH_PERCENT, 0); send_item(CH_LO_V, -64'd300000000);
        send_item(CH_PERCENT, 0); send_item(CH_LO_D, 64'h8000_0000);
        send_item(CH_PERCENT, 0); send_item(CH_LO_Q, 0); send_item(CH_LO_O, '1);
        send_item(CH_PERCENT, 0); send_item(8'h6E, 0);
        send_item(CH_PERCENT, 0); send_item(CH_LO_L, 0); send_item(8'h21, 0);
        // Sender holds off until everything has come out.
        drain();

        write_wide(1'b0);
        send_item(CH_PERCENT, 0); send_item(CH_LO_L, 0); send_item(CH_LO_D, '1);
        for (int n = 0; n < 75; n++)
            send_sequence();
        write_wide(1'b1);
        send_item(CH_PERCENT, 0); send_item(CH_LO_L, 0); send_item(CH_LO_U, '1);
        for (int n = 0; n < 75; n++)
            send_sequence();
        write_wide(1'b0);
        for (int n = 0; n < 20; n++)
            send_sequence();

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("format_integer_to_text_tb passed");
        else
            $display("format_integer_to_text_tb failed");
        $finish;
    end
endmodule

@@ format_integer_to_text.f @@
rtl/fmtint_pkg.sv
rtl/fmtint_ctrl.sv
rtl/fmtint_dp.sv
rtl/format_integer_to_text.sv
tb/format_integer_to_text_tb.sv
